### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by modified_utf8_decoder
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, clk_sig, rst_n_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (prop)) \
        else $error(msg);

// implication checked in the cycle after the trigger, outside reset
`define ASSERT_NEXT(label, clk_sig, rst_n_sig, trig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) \
        (trig) |=> (prop)) else $error(msg);

`endif

### rtl/core/mu8d_pkg.sv
// ----------------------------------------------------------------------------
// mu8d_pkg
// Types and constants of the modified utf-8 decoder
// ----------------------------------------------------------------------------
package mu8d_pkg;

    // status codes of a result
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_LEAD = 2'd1;
    localparam logic [1:0] ST_BAD_CONT = 2'd2;
    localparam logic [1:0] ST_TRUNC    = 2'd3;

    // byte class masks and patterns
    localparam logic [7:0] MASK_CONT  = 8'hC0;
    localparam logic [7:0] PAT_CONT   = 8'h80;
    localparam logic [7:0] MASK_LEAD2 = 8'hE0;
    localparam logic [7:0] PAT_LEAD2  = 8'hC0;
    localparam logic [7:0] MASK_LEAD3 = 8'hF0;
    localparam logic [7:0] PAT_LEAD3  = 8'hE0;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // decoder state carried from byte to byte
    typedef struct packed {
        logic [11:0] partial;
        logic [1:0]  owed;
        logic [15:0] count;
    } mu8d_state_t;

    // one result item plus a flag telling whether the byte gives one
    typedef struct packed {
        logic        present;
        logic [15:0] code_unit;
        logic        unit_valid;
        logic        end_of_string;
        logic [15:0] unit_count;
        logic [1:0]  status;
    } mu8d_result_t;

endpackage

### rtl/core/mu8d_step.sv
// ----------------------------------------------------------------------------
// mu8d_step
// Single-byte decode step: next state and optional result from one byte
// ----------------------------------------------------------------------------
module mu8d_step
(
    input  logic [7:0]            data_byte,
    input  mu8d_pkg::mu8d_state_t state,
    output mu8d_pkg::mu8d_state_t state_next,
    output mu8d_pkg::mu8d_result_t result
);

    logic [17:0] merged;
    logic [15:0] count_inc;
    logic        is_cont;

    // payload merge and saturating count
    assign merged    = {state.partial, data_byte[5:0]};
    assign count_inc = (state.count == mu8d_pkg::COUNT_MAX) ? state.count
                                                            : state.count + 16'd1;
    assign is_cont   = (data_byte & mu8d_pkg::MASK_CONT) == mu8d_pkg::PAT_CONT;

    // byte classification
    always_comb
    begin
        state_next           = state;
        result.present       = 1'b0;
        result.code_unit     = 16'd0;
        result.unit_valid    = 1'b0;
        result.end_of_string = 1'b0;
        result.unit_count    = state.count;
        result.status        = mu8d_pkg::ST_OK;

        if (data_byte == 8'd0)
        begin
            // terminator reports the count then clears everything
            result.present       = 1'b1;
            result.end_of_string = 1'b1;
            result.status        = (state.owed != 2'd0) ? mu8d_pkg::ST_TRUNC
                                                        : mu8d_pkg::ST_OK;
            state_next.partial   = 12'd0;
            state_next.owed      = 2'd0;
            state_next.count     = 16'd0;
        end
        else if (state.owed != 2'd0)
        begin
            if (!is_cont)
            begin
                // broken sequence, drop it and the byte
                result.present     = 1'b1;
                result.status      = mu8d_pkg::ST_BAD_CONT;
                state_next.partial = 12'd0;
                state_next.owed    = 2'd0;
            end
            else if (state.owed == 2'd1)
            begin
                // last continuation completes the unit
                result.present     = 1'b1;
                result.code_unit   = merged[15:0];
                result.unit_valid  = 1'b1;
                result.unit_count  = count_inc;
                state_next.partial = 12'd0;
                state_next.owed    = 2'd0;
                state_next.count   = count_inc;
            end
            else
            begin
                state_next.partial = merged[11:0];
                state_next.owed    = state.owed - 2'd1;
            end
        end
        else if (data_byte[7] == 1'b0)
        begin
            // single-byte unit
            result.present    = 1'b1;
            result.code_unit  = {8'd0, data_byte};
            result.unit_valid = 1'b1;
            result.unit_count = count_inc;
            state_next.count  = count_inc;
        end
        else if ((data_byte & mu8d_pkg::MASK_LEAD2) == mu8d_pkg::PAT_LEAD2)
        begin
            state_next.partial = {7'd0, data_byte[4:0]};
            state_next.owed    = 2'd1;
        end
        else if ((data_byte & mu8d_pkg::MASK_LEAD3) == mu8d_pkg::PAT_LEAD3)
        begin
            state_next.partial = {8'd0, data_byte[3:0]};
            state_next.owed    = 2'd2;
        end
        else
        begin
            // stray continuation or lead of four bytes or more
            result.present = 1'b1;
            result.status  = mu8d_pkg::ST_BAD_LEAD;
        end
    end

endmodule

### rtl/core/modified_utf8_decoder.sv
// ----------------------------------------------------------------------------
// modified_utf8_decoder
// Byte-serial decoder of zero-terminated modified utf-8 into 16-bit units
// ----------------------------------------------------------------------------
//  channel   dir   tdata                      tlast           tuser
//  s_*       in    data_byte[7:0]             -               -
//  m_*       out   code_unit, unit_count      end_of_string   unit_valid, status
//
//  one byte per cycle sustained while the skid entry is empty: a request
//  enters the input register, is decoded against the state registers and
//  any result it gives lands in the output register, which drives m_tvalid.
//  a two-entry output (register plus skid) keeps s_tready a pure register
//  function; a stalled m_tready stops intake once both entries are full.
//  reset clears the decode state, the unit count and all valid flags.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module modified_utf8_decoder
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] code_unit, [31:16] unit_count
    output logic        m_tlast,   // end_of_string
    output logic [2:0]  m_tuser    // [0] unit_valid, [2:1] status
);

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    mu8d_pkg::mu8d_state_t  state_reg;
    mu8d_pkg::mu8d_state_t  state_next;
    mu8d_pkg::mu8d_result_t step_res;
    mu8d_pkg::mu8d_result_t out_reg;
    mu8d_pkg::mu8d_result_t skid_reg;
    logic                   out_valid_reg;
    logic                   skid_valid_reg;
    logic                   advance;
    logic                   in_accept;
    logic                   out_take;

    // handshake
    assign advance   = in_valid_reg && !skid_valid_reg;
    assign s_tready  = !in_valid_reg || advance;
    assign in_accept = s_tvalid && s_tready;
    assign out_take  = out_valid_reg && m_tready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    // decode step
    mu8d_step u_step
    (
        .data_byte  (in_byte_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (step_res)
    );

    // decode state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // output register and skid valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (out_take)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (advance && step_res.present)
            begin
                if (out_valid_reg && !m_tready)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    out_valid_reg <= 1'b1;
                end
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output and skid payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (advance && step_res.present)
        begin
            if (out_valid_reg && !m_tready)
            begin
                skid_reg <= step_res;
            end
            else
            begin
                out_reg <= step_res;
            end
        end
    end

    // port packing
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.unit_count, out_reg.code_unit};
    assign m_tlast  = out_reg.end_of_string;
    assign m_tuser  = {out_reg.status, out_reg.unit_valid};

    // checks
    `ASSERT_CLK(a_skid_behind_out, clk, rst_n,
        !skid_valid_reg || out_valid_reg,
        "skid full while output empty")
    `ASSERT_CLK(a_unit_is_ok, clk, rst_n,
        !(out_valid_reg && out_reg.unit_valid)
            || (out_reg.status == mu8d_pkg::ST_OK && !out_reg.end_of_string),
        "unit result with error or end flag")
    `ASSERT_NEXT(a_eos_clears, clk, rst_n,
        advance && step_res.end_of_string,
        state_reg.count == 16'd0 && state_reg.owed == 2'd0,
        "terminator left state behind")
    `ASSERT_NEXT(a_in_hold, clk, rst_n,
        in_valid_reg && !advance,
        in_valid_reg && $stable(in_byte_reg),
        "pending input byte lost")

endmodule
